// ----- sv/lfu_cache_replacement_core_macros.svh -----
// Assertion macros for the LFU cache replacement core.
// Included by the top level; the checks assume clock clk and reset rst_n in scope.
`ifndef LFU_CACHE_REPLACEMENT_CORE_MACROS_SVH
`define LFU_CACHE_REPLACEMENT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LFU_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("LFU core invariant violated");
// Property whose consequence must hold in the cycle after its antecedent.
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LFU core sequencing violated");
`else
`define LFU_ASSERT(label, expr)
`define LFU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/lfu_pkg.sv -----
// Shared constants for the LFU cache replacement core.
// No dependencies; imported by lfu_cache_replacement_core.
package lfu_pkg;

    localparam int KEY_PORT_W = 16;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int CAP_W      = 5;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Request opcodes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_CAPACITY = 1'b0;

endpackage

// ----- sv/lfu_cache_replacement_core.sv -----
// Top level of the LFU cache replacement core: key/value store with LFU eviction.
// Depends on lfu_pkg and on lfu_cache_replacement_core_macros.svh for its checks.
`include "lfu_cache_replacement_core_macros.svh"

// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+-----------------------------
// request   | opcode, lookup_key, write_value                | taken when start && !busy
// result    | hit, read_value, evicted, evicted_key          | done strobe, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready always high
//
// A get that hits and a put run a scan pass, a decide step and an update pass; a get that
// misses skips the update pass, and a put while the capacity is zero answers without a scan.
// The entry memory returns one entry per cycle: one pass reads every entry to find the key,
// the victim and a free slot, and a second pass rewrites the recency ranks and the target.
// Reset clears the valid bits, occupancy and control state; the entry memory is not cleared.
// The result strobe cannot be held off, so the core never waits on its receiver.
module lfu_cache_replacement_core #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfu_pkg::APB_AW-1:0]        paddr,
    input  logic [lfu_pkg::APB_DW-1:0]        pwdata,
    output logic [lfu_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // Request
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [lfu_pkg::KEY_PORT_W-1:0]    lookup_key,
    input  logic [lfu_pkg::VALUE_W-1:0]       write_value,
    // Result
    output logic                              done,
    output logic                              hit,
    output logic [lfu_pkg::VALUE_W-1:0]       read_value,
    output logic                              evicted,
    output logic [lfu_pkg::KEY_PORT_W-1:0]    evicted_key
);
    import lfu_pkg::*;

    // Stored key width: key bits above KEY_BITS are ignored, and the port has 16 bits.
    localparam int KW   = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;
    localparam logic [IW-1:0]   LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [CNTW-1:0] ENTRIES_C = CNTW'(ENTRIES);

    // One memory word per entry. Rank is the recency age: 0 is the most recent access.
    typedef struct packed {
        logic [KW-1:0]      key;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [IW-1:0]      rank;
    } entry_t;

    // IDLE waits for a request, SCAN reads every entry, DECIDE picks the target slot,
    // UPDATE rewrites ranks and the target entry.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    entry_t entry_mem [ENTRIES];
    entry_t rd_word_reg;

    state_t             state_reg,       state_next;
    logic [CAP_W-1:0]   cap_reg,         cap_next;
    logic [ENTRIES-1:0] valid_reg,       valid_next;
    logic [CNTW-1:0]    occ_reg,         occ_next;
    logic [CNTW-1:0]    issue_cnt_reg,   issue_cnt_next;
    logic               rd_vld_reg,      rd_vld_next;
    logic [IW-1:0]      rd_idx_reg,      rd_idx_next;

    // Latched request.
    logic               op_reg,          op_next;
    logic [KW-1:0]      key_reg,         key_next;
    logic [VALUE_W-1:0] val_reg,         val_next;

    // Scan results.
    logic               hit_found_reg,   hit_found_next;
    logic [IW-1:0]      hit_idx_reg,     hit_idx_next;
    entry_t             hit_word_reg,    hit_word_next;
    logic               vict_found_reg,  vict_found_next;
    logic [IW-1:0]      vict_idx_reg,    vict_idx_next;
    logic [COUNT_W-1:0] vict_cnt_reg,    vict_cnt_next;
    logic [IW-1:0]      vict_rank_reg,   vict_rank_next;
    logic [KW-1:0]      vict_key_reg,    vict_key_next;
    logic               free_found_reg,  free_found_next;
    logic [IW-1:0]      free_idx_reg,    free_idx_next;

    // Update pass: the target slot, its new word and the age threshold below which
    // every other valid entry gets one step older.
    logic [IW-1:0]      tgt_idx_reg,     tgt_idx_next;
    entry_t             tgt_word_reg,    tgt_word_next;
    logic [CNTW-1:0]    thr_reg,         thr_next;

    // Registered result.
    logic                  done_reg,        done_next;
    logic                  hit_reg,         hit_next;
    logic [VALUE_W-1:0]    read_value_reg,  read_value_next;
    logic                  evicted_reg,     evicted_next;
    logic [KEY_PORT_W-1:0] evicted_key_reg, evicted_key_next;

    // Memory ports.
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [IW-1:0] mem_raddr;

    logic            cfg_write;
    logic [CMPW-1:0] cap_eff;
    logic            rd_valid;
    logic            rd_is_victim;
    logic [COUNT_W-1:0] hit_count_inc;

    // Configuration port: writes complete in the access phase, reads are combinational.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_reg) : '0;

    // A capacity above the number of entries acts as the number of entries.
    assign cap_eff = (CMPW'(cap_reg) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_reg);

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    assign mem_raddr = issue_cnt_reg[IW-1:0];
    assign rd_valid  = valid_reg[rd_idx_reg];

    // Victim order: lowest use count first, and among equal counts the oldest access.
    assign rd_is_victim = rd_valid &&
        (!vict_found_reg || (rd_word_reg.count < vict_cnt_reg) ||
         ((rd_word_reg.count == vict_cnt_reg) && (rd_word_reg.rank > vict_rank_reg)));

    assign hit_count_inc = (hit_word_reg.count == COUNT_MAX) ?
                           hit_word_reg.count : hit_word_reg.count + COUNT_W'(1);

    // Entry memory: one write port, one read port, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= entry_mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = issue_cnt_reg[IW-1:0];
        op_next          = op_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_word_next    = hit_word_reg;
        vict_found_next  = vict_found_reg;
        vict_idx_next    = vict_idx_reg;
        vict_cnt_next    = vict_cnt_reg;
        vict_rank_next   = vict_rank_reg;
        vict_key_next    = vict_key_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        tgt_idx_next     = tgt_idx_reg;
        tgt_word_next    = tgt_word_reg;
        thr_next         = thr_reg;
        done_next        = 1'b0;
        hit_next         = hit_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;
        mem_we           = 1'b0;
        mem_waddr        = rd_idx_reg;
        mem_wdata        = rd_word_reg;

        if (cfg_write)
        begin
            cap_next = pwdata[CAP_W-1:0];
        end

        // Both passes issue one read per cycle, entry 0 upward.
        if (((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) && (issue_cnt_reg < ENTRIES_C))
        begin
            rd_vld_next    = 1'b1;
            issue_cnt_next = issue_cnt_reg + CNTW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode;
                    key_next        = lookup_key[KW-1:0];
                    val_next        = write_value;
                    hit_found_next  = 1'b0;
                    vict_found_next = 1'b0;
                    free_found_next = 1'b0;
                    issue_cnt_next  = '0;
                    if ((opcode == OP_PUT) && (cap_eff == '0))
                    begin
                        // Inserts are disabled: answer at once with an all-zero result.
                        done_next        = 1'b1;
                        hit_next         = 1'b0;
                        read_value_next  = '0;
                        evicted_next     = 1'b0;
                        evicted_key_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_valid && (rd_word_reg.key == key_reg) && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_word_next  = rd_word_reg;
                    end
                    if (rd_is_victim)
                    begin
                        vict_found_next = 1'b1;
                        vict_idx_next   = rd_idx_reg;
                        vict_cnt_next   = rd_word_reg.count;
                        vict_rank_next  = rd_word_reg.rank;
                        vict_key_next   = rd_word_reg.key;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                issue_cnt_next   = '0;
                done_next        = 1'b1;
                hit_next         = 1'b0;
                read_value_next  = '0;
                evicted_next     = 1'b0;
                evicted_key_next = '0;
                state_next       = ST_IDLE;
                tgt_word_next.key   = key_reg;
                tgt_word_next.value = val_reg;
                tgt_word_next.count = COUNT_W'(1);
                tgt_word_next.rank  = '0;
                if (hit_found_reg)
                begin
                    // Hit: bump the count, make it most recent, keep or replace the value.
                    hit_next            = 1'b1;
                    tgt_idx_next        = hit_idx_reg;
                    tgt_word_next.count = hit_count_inc;
                    thr_next            = CNTW'(hit_word_reg.rank);
                    state_next          = ST_UPDATE;
                    if (op_reg == OP_GET)
                    begin
                        read_value_next     = hit_word_reg.value;
                        tgt_word_next.value = hit_word_reg.value;
                    end
                end
                else if (op_reg == OP_PUT)
                begin
                    if (CMPW'(occ_reg) >= cap_eff)
                    begin
                        // Full: the victim slot takes the new key. Closing the victim's gap
                        // and then aging every entry nets out to aging those younger than it.
                        if (vict_found_reg)
                        begin
                            evicted_next     = 1'b1;
                            evicted_key_next = KEY_PORT_W'(vict_key_reg);
                            tgt_idx_next     = vict_idx_reg;
                            thr_next         = CNTW'(vict_rank_reg);
                            state_next       = ST_UPDATE;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        // Room left: fill the first free slot and age every stored entry.
                        valid_next[free_idx_reg] = 1'b1;
                        occ_next                 = occ_reg + CNTW'(1);
                        tgt_idx_next             = free_idx_reg;
                        thr_next                 = ENTRIES_C;
                        state_next               = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == tgt_idx_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = tgt_word_reg;
                    end
                    else if (rd_valid && (CNTW'(rd_word_reg.rank) < thr_reg))
                    begin
                        mem_we         = 1'b1;
                        mem_wdata.rank = rd_word_reg.rank + IW'(1);
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cap_reg         <= CAP_RESET;
            valid_reg       <= '0;
            occ_reg         <= '0;
            issue_cnt_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            op_reg          <= OP_GET;
            key_reg         <= '0;
            val_reg         <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_word_reg    <= '0;
            vict_found_reg  <= 1'b0;
            vict_idx_reg    <= '0;
            vict_cnt_reg    <= '0;
            vict_rank_reg   <= '0;
            vict_key_reg    <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            tgt_idx_reg     <= '0;
            tgt_word_reg    <= '0;
            thr_reg         <= '0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            read_value_reg  <= '0;
            evicted_reg     <= 1'b0;
            evicted_key_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cap_reg         <= cap_next;
            valid_reg       <= valid_next;
            occ_reg         <= occ_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_vld_reg      <= rd_vld_next;
            rd_idx_reg      <= rd_idx_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            val_reg         <= val_next;
            hit_found_reg   <= hit_found_next;
            hit_idx_reg     <= hit_idx_next;
            hit_word_reg    <= hit_word_next;
            vict_found_reg  <= vict_found_next;
            vict_idx_reg    <= vict_idx_next;
            vict_cnt_reg    <= vict_cnt_next;
            vict_rank_reg   <= vict_rank_next;
            vict_key_reg    <= vict_key_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            tgt_idx_reg     <= tgt_idx_next;
            tgt_word_reg    <= tgt_word_next;
            thr_reg         <= thr_next;
            done_reg        <= done_next;
            hit_reg         <= hit_next;
            read_value_reg  <= read_value_next;
            evicted_reg     <= evicted_next;
            evicted_key_reg <= evicted_key_next;
        end
    end

    // Occupancy always equals the number of valid entries.
    `LFU_ASSERT(a_occ_matches_valid, $countones(valid_reg) == int'(occ_reg))
    // An accepted request either starts a scan or answers in the next cycle.
    `LFU_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    // The entry memory is written only during the update pass.
    `LFU_ASSERT(a_write_in_update, !mem_we || (state_reg == ST_UPDATE))
    // A result never reports both a hit and an eviction.
    `LFU_ASSERT(a_hit_or_evict, !(done_reg && hit_reg && evicted_reg))

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_replacement_core: LFU key/value store with LRU tie-break.
// Depends on lfu_pkg and the core RTL; holds its own shadow of the store to predict every result.

module tb;

    localparam int SLOTS      = 16;
    localparam int KW         = lfu_pkg::KEY_PORT_W;
    localparam int VW         = lfu_pkg::VALUE_W;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 2 * (2 * SLOTS + 4);
    localparam logic [lfu_pkg::APB_AW-1:0] CAPACITY_ADDR = {lfu_pkg::REG_CAPACITY, 2'b00};

    // What the core must answer for one request.
    typedef struct {
        logic          hit;
        logic [VW-1:0] read_value;
        logic          evicted;
        logic [KW-1:0] evicted_key;
    } lfu_answer_t;

    // Shadow copy of the store. Every accepted request is replayed here and the answer
    // it produces is queued until the core's result strobe comes back for it.
    class lfu_shadow_store;
        bit                           valid    [SLOTS];
        logic [KW-1:0]                key_of   [SLOTS];
        logic [VW-1:0]                value_of [SLOTS];
        logic [lfu_pkg::COUNT_W-1:0]  uses     [SLOTS];
        int unsigned                  age      [SLOTS];
        int unsigned                  occupied;
        logic [lfu_pkg::CAP_W-1:0]    capacity;
        lfu_answer_t                  answers [$];
        int unsigned                  mismatches;
        int unsigned                  hits_seen;
        int unsigned                  evictions_seen;
        int unsigned                  answers_checked;

        function new();
            foreach (valid[i]) valid[i] = 1'b0;
            occupied        = 0;
            capacity        = lfu_pkg::CAP_RESET;
            mismatches      = 0;
            hits_seen       = 0;
            evictions_seen  = 0;
            answers_checked = 0;
        endfunction

        // Append one predicted answer behind those still waiting.
        function void queue_answer(input lfu_answer_t ans);
            answers.insert(answers.size(), ans);
        endfunction

        // Make slot s the most recent; slots younger than it age by one.
        function void touch(input int s);
            int unsigned old;
            old = age[s];
            for (int i = 0; i < SLOTS; i++)
                if (valid[i] && i != s && age[i] < old)
                    age[i]++;
            age[s] = 0;
        endfunction

        // Replay one accepted request and queue the answer it must produce.
        function void note_request(input logic op, input logic [KW-1:0] k,
                                   input logic [VW-1:0] v);
            lfu_answer_t ans;
            int unsigned limit;
            int          s;
            ans   = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
            limit = (capacity > SLOTS) ? SLOTS : capacity;
            s     = -1;
            if (op == lfu_pkg::OP_PUT && limit == 0) begin
                queue_answer(ans);
                return;
            end
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && valid[i] && key_of[i] == k)
                    s = i;
            if (s >= 0) begin
                ans.hit = 1'b1;
                hits_seen++;
                if (uses[s] != lfu_pkg::COUNT_MAX)
                    uses[s]++;
                touch(s);
                if (op == lfu_pkg::OP_GET)
                    ans.read_value = value_of[s];
                else
                    value_of[s] = v;
                queue_answer(ans);
                return;
            end
            if (op == lfu_pkg::OP_GET) begin
                queue_answer(ans);
                return;
            end
            if (occupied >= limit) begin
                // Victim: lowest use count, then the oldest access.
                for (int i = 0; i < SLOTS; i++)
                    if (valid[i] && (s < 0 || uses[i] < uses[s] ||
                                     (uses[i] == uses[s] && age[i] > age[s])))
                        s = i;
                if (s < 0) begin
                    queue_answer(ans);
                    return;
                end
                ans.evicted     = 1'b1;
                ans.evicted_key = key_of[s];
                evictions_seen++;
                for (int i = 0; i < SLOTS; i++)
                    if (valid[i] && i != s && age[i] > age[s])
                        age[i]--;
                valid[s] = 1'b0;
                occupied--;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !valid[i])
                        s = i;
                if (s < 0) begin
                    queue_answer(ans);
                    return;
                end
            end
            for (int i = 0; i < SLOTS; i++)
                if (valid[i])
                    age[i]++;
            valid[s]    = 1'b1;
            key_of[s]   = k;
            value_of[s] = v;
            uses[s]     = 1;
            age[s]      = 0;
            occupied++;
            queue_answer(ans);
        endfunction

        // Compare one result from the core with the oldest queued answer.
        function void check_answer(input logic h, input logic [VW-1:0] rv,
                                   input logic ev, input logic [KW-1:0] ek);
            lfu_answer_t want;
            if (answers.size() == 0) begin
                $error("result with no request pending: hit=%0d read_value=%h evicted=%0d",
                       h, rv, ev);
                mismatches++;
                return;
            end
            want = answers[0];
            answers.delete(0);
            answers_checked++;
            if (h !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, h);
                mismatches++;
            end
            if (rv !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value, rv);
                mismatches++;
            end
            if (ev !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, ev);
                mismatches++;
            end
            if (ek !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, ek);
                mismatches++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lfu_pkg::APB_AW-1:0]      paddr;
    logic [lfu_pkg::APB_DW-1:0]      pwdata;
    logic [lfu_pkg::APB_DW-1:0]      prdata;
    logic                            pready;
    logic                            start;
    logic                            busy;
    logic                            opcode;
    logic [KW-1:0]                   lookup_key;
    logic [VW-1:0]                   write_value;
    logic                            done;
    logic                            hit;
    logic [VW-1:0]                   read_value;
    logic                            evicted;
    logic [KW-1:0]                   evicted_key;

    lfu_shadow_store store;
    int unsigned     requests_sent;
    int unsigned     settings_used;
    int unsigned     quiet_cycles;

    lfu_cache_replacement_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side. The strobe cannot be held off, so every cycle with done high is a result.
    // Sampling at the rising edge sees the values the core held during the cycle just ended.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            store.check_answer(hit, read_value, evicted, evicted_key);
    end

    // Watchdog: any accepted request, returned result or register write counts as progress.
    // The longest correct quiet stretch is the drain at the end of the run, and the limit
    // leaves a wide margin over it.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request and hold it until the core takes it. Start is left high, so a
    // following request goes out back to back; pause or settle lowers it.
    task automatic issue(input logic op, input logic [KW-1:0] k, input logic [VW-1:0] v);
        opcode      <= op;
        lookup_key  <= k;
        write_value <= v;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        store.note_request(op, k, v);
        requests_sent++;
    endtask

    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Every request yields exactly one result, so once the queue is empty and busy has
    // dropped the core is idle; a few extra cycles cover any trailing bookkeeping.
    task automatic settle();
        start <= 1'b0;
        while (store.answers.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register through the APB port, then read it back.
    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        logic [lfu_pkg::APB_DW-1:0] word;
        settle();
        word    = $urandom;
        word[lfu_pkg::CAP_W-1:0] = cap;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        store.capacity = cap;
        settings_used++;
        // The write landed at this edge; roll straight into the read's setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[lfu_pkg::CAP_W-1:0] !== cap) begin
            $error("cache_capacity: expected %0d, got %0d", cap, prdata[lfu_pkg::CAP_W-1:0]);
            store.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic. Keys come mostly from a small pool so that hits, count ties and
    // evictions are frequent; the rest are arbitrary keys and the two key extremes.
    // The sender works in bursts; a quarter of the bursts follow the previous one with no gap.
    task automatic run_mixed_phase(input int unsigned n_requests);
        logic [KW-1:0] pool [24];
        int unsigned   pool_size;
        int unsigned   burst_left;
        int unsigned   roll;
        logic          op;
        logic [KW-1:0] k;
        logic [VW-1:0] v;
        pool_size  = $urandom_range(2, 24);
        burst_left = 0;
        foreach (pool[i]) pool[i] = KW'($urandom);
        repeat (n_requests) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 20));
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (roll < 80)
                k = pool[$urandom_range(0, pool_size - 1)];
            else if (roll < 90)
                k = KW'($urandom);
            else
                k = roll[0] ? {KW{1'b1}} : {KW{1'b0}};
            v = $urandom;
            if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? {VW{1'b1}} : {VW{1'b0}};
            op = ($urandom_range(0, 99) < 45) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
            issue(op, k, v);
        end
    endtask

    initial
    begin
        logic [lfu_pkg::CAP_W-1:0] plan [8];
        logic [KW-1:0]             hot_key;
        plan          = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16};
        store         = new();
        requests_sent = 0;
        settings_used = 0;
        quiet_cycles  = 0;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        start         = 1'b0;
        opcode        = lfu_pkg::OP_GET;
        lookup_key    = '0;
        write_value   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity of 16: a miss on an empty store, both key
        // extremes, the all-ones value (an ordinary value, not a miss marker), an update in
        // place, then a fill to full and an insert that must evict the least recently used
        // of the entries tied at count 1.
        issue(lfu_pkg::OP_GET, '0, 32'hDEAD_BEEF);
        issue(lfu_pkg::OP_PUT, '0, '0);
        issue(lfu_pkg::OP_PUT, {KW{1'b1}}, {VW{1'b1}});
        issue(lfu_pkg::OP_GET, {KW{1'b1}}, '0);
        issue(lfu_pkg::OP_GET, '0, {VW{1'b1}});
        issue(lfu_pkg::OP_PUT, '0, 32'h1234_5678);
        issue(lfu_pkg::OP_GET, '0, '0);
        for (int i = 1; i <= 14; i++)
            issue(lfu_pkg::OP_PUT, KW'(i), VW'(32'hA5A5_0000 | i));
        issue(lfu_pkg::OP_PUT, 16'h8000, 32'h5A5A_5A5A);
        issue(lfu_pkg::OP_GET, 16'h0001, '0);

        // Capacity zero: puts are dropped and answer all zeros, gets still find old entries.
        write_capacity(5'd0);
        issue(lfu_pkg::OP_PUT, 16'h4242, 32'hCAFE_F00D);
        issue(lfu_pkg::OP_GET, {KW{1'b1}}, '0);
        issue(lfu_pkg::OP_PUT, 16'h0002, '0);

        // Capacity above the number of slots behaves as a full store of 16.
        write_capacity(5'd31);
        issue(lfu_pkg::OP_PUT, 16'h7777, 32'h0000_7777);

        // Capacity lowered below occupancy: each put miss evicts one and inserts one.
        // The inserted key is then hit repeatedly, so the next insert must evict one of
        // the rarely used entries and leave the hot key in place.
        write_capacity(5'd2);
        hot_key = 16'h3C3C;
        issue(lfu_pkg::OP_PUT, hot_key, 32'h0BAD_C0DE);
        repeat (20) issue(lfu_pkg::OP_GET, hot_key, VW'($urandom));
        issue(lfu_pkg::OP_PUT, 16'hC3C3, 32'h1111_2222);
        issue(lfu_pkg::OP_GET, hot_key, '0);

        // Random part: eight capacity settings, including both extremes and shrinking a
        // full store down to a single slot.
        foreach (plan[i]) begin
            write_capacity(plan[i]);
            run_mixed_phase(125);
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d requests across %0d capacity settings, from disabled to oversized.",
                 requests_sent, settings_used);
        $display("Checked %0d results: %0d hits and %0d evictions predicted; %0d mismatches.",
                 store.answers_checked, store.hits_seen, store.evictions_seen,
                 store.mismatches);
        if (store.mismatches == 0 && store.answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_cache_replacement_core.sv
tb/tb.sv
